// ----- rtl/irfb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irfb_pkg: shared types and constants for the integer ratio float bounds block
// This package holds the payload structs and the single-precision constants.
// ---------------------------------------------------------------------------
package irfb_pkg;
    localparam int IntWidthDef = 32;
    localparam int SigBits     = 24;
    localparam int FracBits    = 23;
    localparam int ExpBias     = 127;
    localparam logic [7:0] ExpInf = 8'hFF;

    typedef struct packed {
        logic signed [31:0] numerator;
        logic signed [31:0] denominator;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  lower_exponent;
        logic [22:0] lower_fraction;
        logic [7:0]  upper_exponent;
        logic [22:0] upper_fraction;
        logic        quotient_exact;
        logic        divide_by_zero;
    } t_out_item;
endpackage

// ----- rtl/irfb_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irfb_front: operand magnitude and alignment
// Takes magnitudes, finds their bit lengths and aligns the shorter operand to the longer.
// Two register stages.
// ---------------------------------------------------------------------------
module irfb_front #(
    parameter int INT_WIDTH = irfb_pkg::IntWidthDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  irfb_pkg::t_in_item     i_item,
    output logic                   o_valid,
    output logic [INT_WIDTH:0]     o_num,
    output logic [INT_WIDTH:0]     o_den,
    output logic signed [7:0]      o_exp,
    output logic                   o_zero_num,
    output logic                   o_zero_den
);
    import irfb_pkg::*;

    localparam int LW = $clog2(INT_WIDTH + 1);

    // stage a: magnitudes and bit lengths
    logic [INT_WIDTH-1:0] n_a, n_b;
    logic [LW-1:0]        n_la, n_lb;
    logic [INT_WIDTH-1:0] r_a, r_b;
    logic [LW-1:0]        r_la, r_lb;
    logic                 r_va;

    function automatic logic [INT_WIDTH-1:0] mag(input logic [INT_WIDTH-1:0] v);
        mag = v[INT_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [LW-1:0] blen(input logic [INT_WIDTH-1:0] v);
        blen = '0;
        for (int i = 0; i < INT_WIDTH; i++) begin
            if (v[i]) blen = LW'(i + 1);
        end
    endfunction

    always_comb begin
        n_a  = mag(i_item.numerator[INT_WIDTH-1:0]);
        n_b  = mag(i_item.denominator[INT_WIDTH-1:0]);
        n_la = blen(n_a);
        n_lb = blen(n_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= n_a;
            r_b  <= n_b;
            r_la <= n_la;
            r_lb <= n_lb;
        end
    end

    // stage b: align so that num / den lies in [1, 2)
    logic [INT_WIDTH:0] n_num, n_den, sn, sd;
    logic signed [7:0]  n_exp, k;

    always_comb begin
        k  = 8'($signed({1'b0, r_la})) - 8'($signed({1'b0, r_lb}));
        sn = {1'b0, r_a};
        sd = {1'b0, r_b};
        if (r_la >= r_lb) begin
            sd = sd << (r_la - r_lb);
        end else begin
            sn = sn << (r_lb - r_la);
        end
        n_exp = k;
        n_num = sn;
        n_den = sd;
        if (sn < sd) begin
            n_num = sn << 1;
            n_exp = k - 8'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num      <= n_num;
            o_den      <= n_den;
            o_exp      <= n_exp;
            o_zero_num <= (r_a == '0);
            o_zero_den <= (r_b == '0);
        end
    end
endmodule

// ----- rtl/irfb_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irfb_div: pipelined restoring divider
// Produces the 24 significand bits, four bits per register stage.
// ---------------------------------------------------------------------------
module irfb_div #(
    parameter int INT_WIDTH = irfb_pkg::IntWidthDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [INT_WIDTH:0]   i_num,
    input  logic [INT_WIDTH:0]   i_den,
    input  logic signed [7:0]    i_exp,
    input  logic                 i_zero_num,
    input  logic                 i_zero_den,
    output logic                 o_valid,
    output logic [23:0]          o_sig,
    output logic                 o_rem_zero,
    output logic signed [7:0]    o_exp,
    output logic                 o_zero_num,
    output logic                 o_zero_den
);
    import irfb_pkg::*;

    localparam int BitsPerStage = 4;
    localparam int Stages = SigBits / BitsPerStage;
    localparam int RW = INT_WIDTH + 2;

    // stage registers, index s holds the output of stage s
    logic              r_v   [Stages];
    logic [RW-1:0]     r_rem [Stages];
    logic [RW-1:0]     r_den [Stages];
    logic [23:0]       r_sig [Stages];
    logic signed [7:0] r_exp [Stages];
    logic              r_zn  [Stages];
    logic              r_zd  [Stages];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic              v_in;
        logic [RW-1:0]     rem_in;
        logic [RW-1:0]     den_in;
        logic [23:0]       sig_in;
        logic signed [7:0] exp_in;
        logic              zn_in;
        logic              zd_in;
        logic [RW-1:0]     n_rem;
        logic [23:0]       n_sig;

        if (s == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = {1'b0, i_num};
            assign den_in = {1'b0, i_den};
            assign sig_in = '0;
            assign exp_in = i_exp;
            assign zn_in  = i_zero_num;
            assign zd_in  = i_zero_den;
        end else begin : g_next
            assign v_in   = r_v[s-1];
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign sig_in = r_sig[s-1];
            assign exp_in = r_exp[s-1];
            assign zn_in  = r_zn[s-1];
            assign zd_in  = r_zd[s-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_sig = sig_in;
            for (int j = 0; j < BitsPerStage; j++) begin
                n_sig = n_sig << 1;
                if (n_rem >= den_in) begin
                    n_sig[0] = 1'b1;
                    n_rem    = n_rem - den_in;
                end
                n_rem = n_rem << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_den[s] <= den_in;
                r_sig[s] <= n_sig;
                r_exp[s] <= exp_in;
                r_zn[s]  <= zn_in;
                r_zd[s]  <= zd_in;
            end
        end
    end

    assign o_valid    = r_v[Stages-1];
    assign o_sig      = r_sig[Stages-1];
    assign o_rem_zero = (r_rem[Stages-1] == '0);
    assign o_exp      = r_exp[Stages-1];
    assign o_zero_num = r_zn[Stages-1];
    assign o_zero_den = r_zd[Stages-1];
endmodule

// ----- rtl/irfb_round.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irfb_round: directed rounding and result packing
// Forms both bounds and the special-case patterns into one register stage.
// ---------------------------------------------------------------------------
module irfb_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [23:0]          i_sig,
    input  logic                 i_rem_zero,
    input  logic signed [7:0]    i_exp,
    input  logic                 i_zero_num,
    input  logic                 i_zero_den,
    output logic                 o_valid,
    output irfb_pkg::t_out_item  o_item
);
    import irfb_pkg::*;

    t_out_item  n_item;
    logic [24:0] up;
    logic [7:0]  le;

    always_comb begin
        le = 8'(i_exp + 8'sd127);
        up = {1'b0, i_sig} + 25'(!i_rem_zero);
        n_item = '0;
        if (i_zero_den) begin
            n_item.lower_exponent = ExpInf;
            n_item.upper_exponent = ExpInf;
            n_item.divide_by_zero = 1'b1;
        end else if (i_zero_num) begin
            n_item.quotient_exact = 1'b1;
        end else begin
            n_item.lower_exponent = le;
            n_item.lower_fraction = i_sig[22:0];
            n_item.quotient_exact = i_rem_zero;
            if (up[24]) begin
                n_item.upper_exponent = le + 8'd1;
                n_item.upper_fraction = up[23:1];
            end else begin
                n_item.upper_exponent = le;
                n_item.upper_fraction = up[22:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_item <= n_item;
        end
    end
endmodule

// ----- rtl/int_ratio_float_bounds.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// int_ratio_float_bounds: single-precision bounds of an integer ratio
// Gives |num|/|den| rounded toward and away from zero, plus exact and
// divide-by-zero flags.
// ---------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall with payload i_item (numerator,
//   denominator); a transfer happens when i_valid is high and o_stall low
//   output channel: o_valid / i_stall with payload o_item; a transfer
//   happens when o_valid is high and i_stall low
//   pipeline: two front stages, six divider stages of four quotient
//   bits and one rounding stage between input transfer and result valid
//   throughput: one item per cycle unless stalled (pipelined divider)
//   stall: the whole pipeline freezes while a valid result waits under
//   i_stall; bubbles are held as well, so o_stall is high exactly then
//   reset: all valid bits clear, no item is in flight afterwards
// ---------------------------------------------------------------------------
module int_ratio_float_bounds #(
    parameter int INT_WIDTH = irfb_pkg::IntWidthDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  irfb_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output irfb_pkg::t_out_item  o_item
);
    import irfb_pkg::*;

    logic en;

    logic                 f_v, f_zn, f_zd;
    logic [INT_WIDTH:0]   f_num, f_den;
    logic signed [7:0]    f_exp;

    logic                 d_v, d_rz, d_zn, d_zd;
    logic [23:0]          d_sig;
    logic signed [7:0]    d_exp;

    // pipeline advances unless the held result is blocked
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    irfb_front #(.INT_WIDTH(INT_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .o_valid    (f_v),
        .o_num      (f_num),
        .o_den      (f_den),
        .o_exp      (f_exp),
        .o_zero_num (f_zn),
        .o_zero_den (f_zd)
    );

    irfb_div #(.INT_WIDTH(INT_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (f_v),
        .i_num      (f_num),
        .i_den      (f_den),
        .i_exp      (f_exp),
        .i_zero_num (f_zn),
        .i_zero_den (f_zd),
        .o_valid    (d_v),
        .o_sig      (d_sig),
        .o_rem_zero (d_rz),
        .o_exp      (d_exp),
        .o_zero_num (d_zn),
        .o_zero_den (d_zd)
    );

    irfb_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d_v),
        .i_sig      (d_sig),
        .i_rem_zero (d_rz),
        .i_exp      (d_exp),
        .i_zero_num (d_zn),
        .i_zero_den (d_zd),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );
endmodule
